@@ hdl/ptpc_pkg.sv @@
package ptpc_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;

   // divider: one prep stage plus one stage per quotient bit
   localparam int QUO_BITS = 33;
   localparam int DIV_LAT  = QUO_BITS + 1;

   // constants for fixed point
   localparam logic signed [32:0] ONE_Q     = 33'(1) << FRAC_BITS;
   localparam logic signed [45:0] TRUNC_BIAS = (46'(1) << (FRAC_BITS + 1)) - 46'(1);

   // colour ramp band limits
   localparam logic [7:0] RAMP_T1 = 8'd245;
   localparam logic [7:0] RAMP_T2 = 8'd235;
   localparam logic [7:0] RAMP_T3 = 8'd225;
   localparam logic [7:0] RAMP_T4 = 8'd210;
   localparam logic [7:0] FULL    = 8'd255;

   localparam logic [3:0] COEF_COUNT = 4'd12;
   localparam logic [3:0] TRANS_BASE = 4'd9;

   typedef enum logic {
      OP_LOAD      = 1'b0,
      OP_TRANSFORM = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_PROJ_X_SCALE    = 3'd0,
      CSR_PROJ_Y_SCALE    = 3'd1,
      CSR_SCREEN_WIDTH    = 3'd2,
      CSR_SCREEN_HEIGHT   = 3'd3,
      CSR_INV_SPAN        = 3'd4,
      CSR_FLATTEN         = 3'd5,
      CSR_HEIGHT_MIN      = 3'd6,
      CSR_INV_HEIGHT_SPAN = 3'd7
   } csr_type;

   typedef struct packed {
      logic               operation;
      logic [3:0]         coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               in_view;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } rsp_type;

   // colour word travelling beside the geometry
   typedef struct packed {
      logic       valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } clr_type;

   // translated point from the transform stages
   typedef struct packed {
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
   } xf_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/ptpc_xform.sv @@
module ptpc_xform import ptpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic [31:0] inv_span,
   input  logic        flatten,
   output xf_type      xf
);

   logic [31:0] coef_ff [0:11];

   // stage 1: scale products
   logic               ld1_ff;
   logic [3:0]         idx1_ff;
   logic [31:0]        val1_ff;
   logic signed [63:0] px1_ff, py1_ff, pz1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ld1_ff <= 1'b0;
      end else begin
         ld1_ff <= accept && (req.operation == OP_LOAD);
      end
      idx1_ff <= req.coef_index;
      val1_ff <= req.coef_value;
      px1_ff  <= 64'(req.point_x * $signed({1'b0, inv_span}));
      py1_ff  <= 64'(req.point_y * $signed({1'b0, inv_span}));
      pz1_ff  <= 64'(req.point_z * $signed({1'b0, inv_span}));
   end

   // stage 2: floor shift and saturate, y negated
   logic               ld2_ff;
   logic [3:0]         idx2_ff;
   logic [31:0]        val2_ff;
   logic signed [31:0] s_ff [0:2];
   logic signed [63:0] ny_in;

   assign ny_in = -py1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ld2_ff <= 1'b0;
      end else begin
         ld2_ff <= ld1_ff;
      end
      idx2_ff <= idx1_ff;
      val2_ff <= val1_ff;
      s_ff[0] <= sat32(66'(px1_ff >>> FRAC_BITS));
      s_ff[1] <= sat32(66'(ny_in >>> FRAC_BITS));
      s_ff[2] <= flatten ? 32'sd0 : sat32(66'(pz1_ff >>> FRAC_BITS));
   end

   // coefficient writes, taken in order with the points behind them
   always_ff @(posedge clock) begin
      if (ld2_ff && (idx2_ff < COEF_COUNT)) begin
         coef_ff[idx2_ff] <= val2_ff;
      end
   end

   // stage 3: nine rotation products, translation captured alongside
   logic signed [63:0] prod_ff [0:8];
   logic signed [31:0] trans_ff [0:2];

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[r * 3 + c] <= 64'(s_ff[r] * $signed(coef_ff[r * 3 + c]));
         end
      end
      for (int c = 0; c < 3; c++) begin
         trans_ff[c] <= $signed(coef_ff[32'(TRANS_BASE) + c]);
      end
   end

   // stage 4: column sums, floor shift, translate
   logic signed [65:0] sum_in [0:2];
   logic signed [31:0] t_ff [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = ((66'(prod_ff[c]) + 66'(prod_ff[3 + c]) + 66'(prod_ff[6 + c]))
                     >>> FRAC_BITS) + 66'(trans_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         t_ff[c] <= sat32(sum_in[c]);
      end
   end

   assign xf.tx = t_ff[0];
   assign xf.ty = t_ff[1];
   assign xf.tz = t_ff[2];

endmodule

@@ hdl/ptpc_div.sv @@
module ptpc_div import ptpc_pkg::*; (
   input  logic                    clock,
   input  logic signed [56:0]      num,
   input  logic signed [31:0]      den,
   output logic [QUO_BITS-1:0]     quo,
   output logic                    neg,
   output logic                    ovf,
   output logic                    zero
);

   // per stage state: remainder, divisor magnitude, quotient so far, flags
   logic [56:0]         rem_ff  [0:QUO_BITS];
   logic [31:0]         ad_ff   [0:QUO_BITS];
   logic [QUO_BITS-1:0] q_ff    [0:QUO_BITS];
   logic                neg_ff  [0:QUO_BITS];
   logic                ovf_ff  [0:QUO_BITS];
   logic                zero_ff [0:QUO_BITS];

   logic [56:0] an_in;
   logic [31:0] ad_in;

   // prep: magnitudes, sign and overflow of the top quotient bits
   assign an_in = num[56] ? 57'(-num) : 57'(num);
   assign ad_in = den[31] ? 32'(-den) : 32'(den);

   always_ff @(posedge clock) begin
      rem_ff[0]  <= an_in;
      ad_ff[0]   <= ad_in;
      q_ff[0]    <= '0;
      neg_ff[0]  <= num[56] ^ den[31];
      ovf_ff[0]  <= {8'd0, an_in[56:33]} >= ad_in;
      zero_ff[0] <= (den == 32'sd0);
   end

   // one restoring step per stage, msb first
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
      logic [64:0] dsh;
      logic        fit;
      assign dsh = {33'd0, ad_ff[i]} << (QUO_BITS - 1 - i);
      assign fit = {8'd0, rem_ff[i]} >= dsh;
      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= fit ? 57'({8'd0, rem_ff[i]} - dsh) : rem_ff[i];
         ad_ff[i+1]   <= ad_ff[i];
         q_ff[i+1]    <= {q_ff[i][QUO_BITS-2:0], fit};
         neg_ff[i+1]  <= neg_ff[i];
         ovf_ff[i+1]  <= ovf_ff[i];
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   assign quo  = q_ff[QUO_BITS];
   assign neg  = neg_ff[QUO_BITS];
   assign ovf  = ovf_ff[QUO_BITS];
   assign zero = zero_ff[QUO_BITS];

endmodule

@@ hdl/ptpc_colour.sv @@
module ptpc_colour import ptpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] height_min,
   input  logic [31:0]        inv_height_span,
   output clr_type            clr
);

   // stage 1: height above minimum
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [32:0] diff_ff;
   logic [63:0]        h_ff;
   logic [7:0]         ratio_ff;
   logic [47:0]        hs_in;
   logic [FRAC_BITS+7:0] hm_in;
   logic [7:0]         ratio_in;
   clr_type            clr_ff;
   clr_type            clr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      diff_ff <= 33'(point_y) - 33'(height_min);
   end

   // stage 2: scale by inverse height span
   always_ff @(posedge clock) begin
      if (diff_ff > 33'sd0) begin
         h_ff <= diff_ff[31:0] * inv_height_span;
      end else begin
         h_ff <= '0;
      end
   end

   // stage 3: ratio 0..255 with saturation
   assign hs_in = h_ff[63:FRAC_BITS];
   assign hm_in = (FRAC_BITS + 8)'(hs_in[FRAC_BITS-1:0]) * (FRAC_BITS + 8)'(FULL);
   assign ratio_in = (hs_in >= (48'(1) << FRAC_BITS)) ? FULL : hm_in[FRAC_BITS+7:FRAC_BITS];

   always_ff @(posedge clock) begin
      ratio_ff <= ratio_in;
   end

   // stage 4: five band ramp
   always_comb begin
      clr_in.valid = v3_ff;
      if (ratio_ff > RAMP_T1) begin
         clr_in.red = FULL;             clr_in.green = ratio_ff;        clr_in.blue = 8'd0;
      end else if (ratio_ff > RAMP_T2) begin
         clr_in.red = FULL - ratio_ff;  clr_in.green = FULL;            clr_in.blue = 8'd0;
      end else if (ratio_ff > RAMP_T3) begin
         clr_in.red = 8'd0;             clr_in.green = FULL;            clr_in.blue = ratio_ff;
      end else if (ratio_ff > RAMP_T4) begin
         clr_in.red = 8'd0;             clr_in.green = FULL - ratio_ff; clr_in.blue = FULL;
      end else begin
         clr_in.red = ratio_ff;         clr_in.green = 8'd0;            clr_in.blue = FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   assign clr = '{valid: clr_ff.valid && v4_ff, red: clr_ff.red,
                  green: clr_ff.green, blue: clr_ff.blue};

endmodule

@@ hdl/point_transform_project_colour.sv @@
// result path: transform, numerator, divider, quotient, viewport, output registers
// throughput: one item per cycle, set by the fully pipelined divider pair
// load words write the coefficient table and produce no result word
// reset clears all valid bits and restores register defaults; coefficients stay unset
// busy stays low, so start is always taken; the receiver cannot stall
module point_transform_project_colour import ptpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int CLR_DELAY = DIV_LAT + 3;

   // configuration registers
   logic [23:0]        proj_x_scale_ff, proj_y_scale_ff;
   logic [11:0]        screen_width_ff, screen_height_ff;
   logic [31:0]        inv_span_ff, inv_height_span_ff;
   logic               flatten_ff;
   logic signed [31:0] height_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_x_scale_ff    <= 24'd65536;
         proj_y_scale_ff    <= 24'd65536;
         screen_width_ff    <= 12'd256;
         screen_height_ff   <= 12'd140;
         inv_span_ff        <= 32'd65536;
         flatten_ff         <= 1'b0;
         height_min_ff      <= 32'sd0;
         inv_height_span_ff <= 32'd65536;
      end else if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_PROJ_X_SCALE:    proj_x_scale_ff    <= csr_wdata[23:0];
            CSR_PROJ_Y_SCALE:    proj_y_scale_ff    <= csr_wdata[23:0];
            CSR_SCREEN_WIDTH:    screen_width_ff    <= csr_wdata[11:0];
            CSR_SCREEN_HEIGHT:   screen_height_ff   <= csr_wdata[11:0];
            CSR_INV_SPAN:        inv_span_ff        <= csr_wdata;
            CSR_FLATTEN:         flatten_ff         <= csr_wdata[0];
            CSR_HEIGHT_MIN:      height_min_ff      <= csr_wdata;
            CSR_INV_HEIGHT_SPAN: inv_height_span_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // rotation and translation
   xf_type xf;

   ptpc_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .inv_span (inv_span_ff),
      .flatten  (flatten_ff),
      .xf       (xf)
   );

   // height colour
   clr_type clr;

   ptpc_colour u_colour (
      .clock           (clock),
      .reset           (reset),
      .valid           (accept && (req_data.operation == OP_TRANSFORM)),
      .point_y         (req_data.point_y),
      .height_min      (height_min_ff),
      .inv_height_span (inv_height_span_ff),
      .clr             (clr)
   );

   // colour and valid wait for the geometry
   clr_type dly_ff [0:CLR_DELAY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLR_DELAY; i++) begin
            dly_ff[i] <= '0;
         end
      end else begin
         dly_ff[0] <= clr;
         for (int i = 1; i < CLR_DELAY; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   // projection numerators
   logic signed [56:0] numx_ff, numy_ff;
   logic signed [31:0] tz_ff;

   always_ff @(posedge clock) begin
      numx_ff <= 57'(xf.tx * $signed({1'b0, proj_x_scale_ff}));
      numy_ff <= 57'(xf.ty * $signed({1'b0, proj_y_scale_ff}));
      tz_ff   <= xf.tz;
   end

   // perspective divide
   logic [QUO_BITS-1:0] qx, qy;
   logic                negx, negy, ovfx, ovfy, zerox, zeroy;

   ptpc_div u_div_x (
      .clock (clock), .num (numx_ff), .den (tz_ff),
      .quo (qx), .neg (negx), .ovf (ovfx), .zero (zerox)
   );

   ptpc_div u_div_y (
      .clock (clock), .num (numy_ff), .den (tz_ff),
      .quo (qy), .neg (negy), .ovf (ovfy), .zero (zeroy)
   );

   // signed quotient with saturation
   logic signed [31:0] ndcx_ff, ndcy_ff;
   logic               zn_ff;
   logic               bigx_in, bigy_in;

   assign bigx_in = ovfx || (negx ? (qx > 33'h080000000) : (qx > 33'h07FFFFFFF));
   assign bigy_in = ovfy || (negy ? (qy > 33'h080000000) : (qy > 33'h07FFFFFFF));

   always_ff @(posedge clock) begin
      ndcx_ff <= bigx_in ? (negx ? 32'sh80000000 : 32'sh7FFFFFFF)
                         : (negx ? 32'(-qx) : 32'(qx));
      ndcy_ff <= bigy_in ? (negy ? 32'sh80000000 : 32'sh7FFFFFFF)
                         : (negy ? 32'(-qy) : 32'(qy));
      zn_ff   <= zerox || zeroy;
   end

   // viewport scaling
   logic signed [45:0] vx_ff, vy_ff;
   logic               zv_ff;

   always_ff @(posedge clock) begin
      vx_ff <= 46'((33'(ndcx_ff) + ONE_Q) * $signed({1'b0, screen_width_ff}));
      vy_ff <= 46'((33'(ndcy_ff) + ONE_Q) * $signed({1'b0, screen_height_ff}));
      zv_ff <= zn_ff;
   end

   // truncate toward zero, saturate, viewport test
   logic signed [45:0] ax_in, ay_in;
   logic signed [15:0] sx_in, sy_in;
   logic               view_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign ax_in = (vx_ff[45] ? vx_ff + TRUNC_BIAS : vx_ff) >>> (FRAC_BITS + 1);
   assign ay_in = (vy_ff[45] ? vy_ff + TRUNC_BIAS : vy_ff) >>> (FRAC_BITS + 1);

   always_comb begin
      if (zv_ff) begin
         sx_in = 16'sd0;
      end else if (ax_in > 46'sd32767) begin
         sx_in = 16'sh7FFF;
      end else if (ax_in < -46'sd32768) begin
         sx_in = 16'sh8000;
      end else begin
         sx_in = ax_in[15:0];
      end
      if (zv_ff) begin
         sy_in = 16'sd0;
      end else if (ay_in > 46'sd32767) begin
         sy_in = 16'sh7FFF;
      end else if (ay_in < -46'sd32768) begin
         sy_in = 16'sh8000;
      end else begin
         sy_in = ay_in[15:0];
      end
      view_in = !zv_ff && !sx_in[15] && !sy_in[15]
                && (16'(sx_in) < {4'd0, screen_width_ff})
                && (16'(sy_in) < {4'd0, screen_height_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dly_ff[CLR_DELAY-1].valid;
      end
      rsp_data_ff.screen_x <= sx_in;
      rsp_data_ff.screen_y <= sy_in;
      rsp_data_ff.in_view  <= view_in;
      rsp_data_ff.red      <= dly_ff[CLR_DELAY-1].red;
      rsp_data_ff.green    <= dly_ff[CLR_DELAY-1].green;
      rsp_data_ff.blue     <= dly_ff[CLR_DELAY-1].blue;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
